>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the governor modules. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

>>> rtl/core/ftqg_pkg.sv
// ---------------------------------------------------------------------------
// ftqg_pkg
// Shared widths, constants, sequencer states and control structs for the
// frame time quality governor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftqg_pkg;

  // Serial divider geometry: three quotient bits are resolved per cycle.
  localparam int DIG   = 3;
  localparam int DVD_W = 66;  // widest dividend: ticks * 1000 * 2^16
  localparam int DVS_W = 40;  // widest divisor: tick frequency
  localparam int Q_W   = 32;  // quotient bits kept, higher bits flag overflow

  // Divider passes, in digits. Each dividend length is a multiple of DIG.
  localparam int MS_STEPS  = DVD_W / DIG;  // 66-bit ms conversion
  localparam int AVG_STEPS = 36 / DIG;     // 36-bit smoothing sum
  localparam int BUD_STEPS = 42 / DIG;     // 42-bit budget product
  localparam int CNT_W     = $clog2(MS_STEPS);

  // Field widths.
  localparam int TICK_W = 40;
  localparam int NS_W   = 32;
  localparam int MS_W   = 32;
  localparam int BUD_W  = 24;
  localparam int QUAL_W = 10;
  localparam int DROP_W = 32;
  localparam int FPS_W  = 10;
  localparam int SUM_W  = 36;
  localparam int PROD_W = 42;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_FPS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_TICK_FREQ  = CFG_ADDR_W'(1);

  localparam logic [FPS_W-1:0]  FPS_RESET  = FPS_W'(60);
  localparam logic [DVS_W-1:0]  FREQ_RESET = DVS_W'(1000000000);

  // Constant divisors.
  localparam logic [DVS_W-1:0] DVS_NS_PER_MS = DVS_W'(1000000);
  localparam logic [DVS_W-1:0] DVS_TEN       = DVS_W'(10);
  localparam logic [DVS_W-1:0] DVS_KILO      = DVS_W'(1000);

  // Governor thresholds on P = avg_gpu * target_fps.
  // Over budget: 20P > 19 * 65536000, i.e. P > 62259200.
  // Under budget: 4P < 3 * 65536000, i.e. P < 49152000.
  localparam logic [PROD_W-1:0] P_OVER  = PROD_W'(62259200);
  localparam logic [PROD_W-1:0] P_UNDER = PROD_W'(49152000);

  localparam logic [QUAL_W-1:0] Q_MIN = QUAL_W'(500);
  localparam logic [QUAL_W-1:0] Q_MAX = QUAL_W'(1000);
  localparam logic [QUAL_W-1:0] Q_DROP_FLOOR = QUAL_W'(502);

  // Stream payload widths.
  localparam int S_DATA_W = 72;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 168;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MS,
    ST_PICK,
    ST_AVG_DIV,
    ST_AVG_WR,
    ST_MUL,
    ST_BUD_DIV,
    ST_RESULT
  } ftqg_state_t;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic take;    // input side ready
    logic ld_ms;   // load dividers for the ms conversions
    logic ld_avg;  // load dividers for the smoothing divides
    logic ld_bud;  // form the product and load the budget divide
    logic step;    // advance the dividers by one digit
    logic pick;    // ms quotients are final
    logic avg_wr;  // smoothing quotients are final
    logic fin;     // commit governor state and the result
  } ftqg_ctl_t;

  // Datapath status to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic use_smp;
    logic seeded;
    logic out_free;
  } ftqg_sts_t;

endpackage

>>> rtl/core/ftqg_sdiv.sv
// ---------------------------------------------------------------------------
// ftqg_sdiv
// Serial restoring divider. The dividend shifts out MSB first, DIG bits per
// step; quotient bits above Q_W are folded into a sticky overflow flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftqg_sdiv (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [ftqg_pkg::DVD_W-1:0] dvd_in,
  input  logic [ftqg_pkg::DVS_W-1:0] dvs_in,
  output logic [ftqg_pkg::Q_W-1:0]   quo,
  output logic                      ovf
);
  import ftqg_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] dvd_next;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] rem_next;
  logic [Q_W-1:0]   quo_r;
  logic [Q_W-1:0]   quo_next;
  logic             ovf_r;
  logic             ovf_next;
  logic [DVS_W:0]   trial;

  // One digit: DIG dependent shift-compare-subtract steps.
  always_comb begin
    rem_next = rem;
    dvd_next = dvd;
    quo_next = quo_r;
    ovf_next = ovf_r;
    trial    = '0;
    for (int j = 0; j < DIG; j++) begin
      trial    = {rem_next, dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      ovf_next = ovf_next | quo_next[Q_W-1];
      if (trial >= {1'b0, dvs}) begin
        rem_next = DVS_W'(trial - {1'b0, dvs});
        quo_next = {quo_next[Q_W-2:0], 1'b1};
      end else begin
        rem_next = trial[DVS_W-1:0];
        quo_next = {quo_next[Q_W-2:0], 1'b0};
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd   <= dvd_in;
      dvs   <= dvs_in;
      rem   <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (step) begin
      dvd   <= dvd_next;
      rem   <= rem_next;
      quo_r <= quo_next;
      ovf_r <= ovf_next;
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

>>> rtl/core/ftqg_ctrl.sv
// ---------------------------------------------------------------------------
// ftqg_ctrl
// Sequencer for one frame: ms conversion, optional smoothing, product,
// budget divide and result hand-off, with the shared digit counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftqg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ftqg_pkg::ftqg_sts_t sts,
  output ftqg_pkg::ftqg_ctl_t ctl
);
  import ftqg_pkg::*;

  localparam logic [CNT_W-1:0] MS_LAST  = CNT_W'(MS_STEPS - 1);
  localparam logic [CNT_W-1:0] AVG_LAST = CNT_W'(AVG_STEPS - 1);
  localparam logic [CNT_W-1:0] BUD_LAST = CNT_W'(BUD_STEPS - 1);

  ftqg_state_t      state;
  ftqg_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic             last;

  // Last digit of the current divider pass.
  always_comb begin
    case (state)
      ST_DIV_MS:  last = (cnt == MS_LAST);
      ST_AVG_DIV: last = (cnt == AVG_LAST);
      ST_BUD_DIV: last = (cnt == BUD_LAST);
      default:    last = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (sts.in_valid) state_next = ST_DIV_MS;
      ST_DIV_MS:  if (last) state_next = ST_PICK;
      ST_PICK: begin
        if (sts.use_smp && sts.seeded) state_next = ST_AVG_DIV;
        else state_next = ST_MUL;
      end
      ST_AVG_DIV: if (last) state_next = ST_AVG_WR;
      ST_AVG_WR:  state_next = ST_MUL;
      ST_MUL:     state_next = ST_BUD_DIV;
      ST_BUD_DIV: if (last) state_next = ST_RESULT;
      ST_RESULT:  if (sts.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.take  = 1'b1;
        ctl.ld_ms = sts.in_valid;
      end
      ST_DIV_MS:  ctl.step = 1'b1;
      ST_PICK: begin
        ctl.pick   = 1'b1;
        ctl.ld_avg = sts.use_smp && sts.seeded;
      end
      ST_AVG_DIV: ctl.step   = 1'b1;
      ST_AVG_WR:  ctl.avg_wr = 1'b1;
      ST_MUL:     ctl.ld_bud = 1'b1;
      ST_BUD_DIV: ctl.step   = 1'b1;
      ST_RESULT:  ctl.fin    = sts.out_free;
      default:    ctl = '0;
    endcase
  end

  // State and digit counter; the counter restarts on every state change.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else if (ctl.step) cnt <= cnt + CNT_W'(1);
    end
  end

  `ASSERT_NEVER(a_one_cmd, clk, rst, !$onehot0({ctl.ld_ms, ctl.ld_avg, ctl.ld_bud, ctl.step}), "divider commands overlap")
  `ASSERT_PROP(a_fin_idle, clk, rst, ctl.fin |=> ctl.take, "sequencer did not return to idle after commit")
  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt > MS_LAST, "digit counter ran past the longest pass")

endmodule

>>> rtl/core/frame_time_quality_governor_core.sv
// ---------------------------------------------------------------------------
// frame_time_quality_governor_core
// Per-frame GPU/CPU time smoothing and dynamic quality governor built on
// two serial radix-8 dividers.
// ---------------------------------------------------------------------------
//   channel   group                        fields (low bit first)
//   input     s_tvalid/s_tready/tdata/tuser gpu_ticks, cpu_elapsed_ns |
//                                           sample_ready, disjoint_flag
//   output    m_tvalid/m_tready/m_tdata    gpu_ms_smoothed .. drop_count
//   config    cfg_valid/cfg_ready          cfg_addr, cfg_data
//
// Each frame runs the dividers for 22 digits of ms conversion, 12 digits of
// smoothing and 14 digits of budget divide, at three quotient bits per cycle.
// The smoothing pass runs only when the averages are smoothed; it is skipped
// when the sample is unused or seeds them. The result sits in an output
// register, so a new frame is taken while the result waits; a stalled output
// holds the sequencer at its last step. Reset is synchronous and needs no
// clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frame_time_quality_governor_core (
  input  logic                           clk,
  input  logic                           rst,
  // Frame request in.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [39:0] gpu_ticks, [71:40] cpu_elapsed_ns
  input  logic [ftqg_pkg::S_DATA_W-1:0]   s_tdata,
  // [0] sample_ready, [1] disjoint_flag
  input  logic [ftqg_pkg::S_USER_W-1:0]   s_tuser,
  // Result request out.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] gpu_ms_smoothed, [63:32] cpu_ms_smoothed, [95:64] present_ms,
  // [119:96] budget_ratio, [129:120] quality_permille, [161:130] drop_count,
  // [167:162] zero
  output logic [ftqg_pkg::M_DATA_W-1:0]   m_tdata,
  // Register writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ftqg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ftqg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ftqg_pkg::*;

  ftqg_ctl_t ctl;
  ftqg_sts_t sts;

  // Configuration registers.
  logic [FPS_W-1:0] fps;
  logic [DVS_W-1:0] freq;

  // Governor state.
  logic [MS_W-1:0]   avg_gpu;
  logic [MS_W-1:0]   avg_cpu;
  logic              seeded;
  logic [QUAL_W-1:0] quality;
  logic [DROP_W-1:0] drops;
  logic              use_smp;

  // Per-frame working values.
  logic [MS_W-1:0]   present;
  logic [PROD_W-1:0] prod;

  // Divider wiring.
  logic             ld0;
  logic             ld1;
  logic [DVD_W-1:0] dvd0;
  logic [DVD_W-1:0] dvd1;
  logic [DVS_W-1:0] dvs0;
  logic [DVS_W-1:0] dvs1;
  logic [Q_W-1:0]   quo0;
  logic [Q_W-1:0]   quo1;
  logic             ovf0;
  logic             ovf1;

  // Combinational helpers.
  logic [TICK_W-1:0] gpu_ticks;
  logic [NS_W-1:0]   cpu_ns;
  logic [49:0]       ticks_k;
  logic [MS_W-1:0]   gpu_ms;
  logic [MS_W-1:0]   cpu_ms;
  logic [SUM_W-1:0]  sum_gpu;
  logic [SUM_W-1:0]  sum_cpu;
  logic [PROD_W-1:0] prod_c;
  logic [BUD_W-1:0]  budget;
  logic              over;
  logic              under;
  logic [QUAL_W-1:0] quality_next;
  logic [DROP_W-1:0] drops_next;

  // Output register.
  logic [MS_W-1:0]   o_gpu;
  logic [MS_W-1:0]   o_cpu;
  logic [MS_W-1:0]   o_present;
  logic [BUD_W-1:0]  o_budget;
  logic [QUAL_W-1:0] o_quality;
  logic [DROP_W-1:0] o_drops;

  ftqg_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  assign sts.in_valid = s_tvalid;
  assign sts.use_smp  = use_smp;
  assign sts.seeded   = seeded;
  assign sts.out_free = !m_tvalid || m_tready;

  assign s_tready  = ctl.take;
  assign cfg_ready = 1'b1;

  assign gpu_ticks = s_tdata[TICK_W-1:0];
  assign cpu_ns    = s_tdata[TICK_W +: NS_W];

  // ticks * 1000 as 1024 - 16 - 8.
  assign ticks_k = {gpu_ticks, 10'b0} - {6'b0, gpu_ticks, 4'b0} - {7'b0, gpu_ticks, 3'b0};

  // Saturated GPU and CPU ms from the first pass.
  assign gpu_ms = ovf0 ? '1 : quo0;
  assign cpu_ms = ovf1 ? '1 : quo1;

  // 9 * avg + x + 5 for the rounded smoothing divide.
  assign sum_gpu = {1'b0, avg_gpu, 3'b0} + {4'b0, avg_gpu} + {4'b0, gpu_ms} + SUM_W'(5);
  assign sum_cpu = {1'b0, avg_cpu, 3'b0} + {4'b0, avg_cpu} + {4'b0, cpu_ms} + SUM_W'(5);

  assign prod_c = PROD_W'(avg_gpu) * PROD_W'(fps);

  // Divider operand selection per pass.
  assign ld0 = ctl.ld_ms || ctl.ld_avg || ctl.ld_bud;
  assign ld1 = ctl.ld_ms || ctl.ld_avg;

  always_comb begin
    if (ctl.ld_ms) begin
      dvd0 = {ticks_k, 16'b0};
      dvs0 = freq;
      dvd1 = {18'b0, cpu_ns, 16'b0};
      dvs1 = DVS_NS_PER_MS;
    end else if (ctl.ld_avg) begin
      dvd0 = {sum_gpu, 30'b0};
      dvs0 = DVS_TEN;
      dvd1 = {sum_cpu, 30'b0};
      dvs1 = DVS_TEN;
    end else begin
      dvd0 = {prod_c, 24'b0};
      dvs0 = DVS_KILO;
      dvd1 = '0;
      dvs1 = DVS_TEN;
    end
  end

  ftqg_sdiv u_div0 (
    .clk    (clk),
    .load   (ld0),
    .step   (ctl.step),
    .dvd_in (dvd0),
    .dvs_in (dvs0),
    .quo    (quo0),
    .ovf    (ovf0)
  );

  ftqg_sdiv u_div1 (
    .clk    (clk),
    .load   (ld1),
    .step   (ctl.step),
    .dvd_in (dvd1),
    .dvs_in (dvs1),
    .quo    (quo1),
    .ovf    (ovf1)
  );

  // Budget saturation and governor decision.
  assign budget = (|quo0[Q_W-1:BUD_W]) ? '1 : quo0[BUD_W-1:0];
  assign over   = prod > P_OVER;
  assign under  = prod < P_UNDER;

  always_comb begin
    quality_next = quality;
    drops_next   = drops;
    if (over) begin
      quality_next = (quality < Q_DROP_FLOOR) ? Q_MIN : quality - QUAL_W'(2);
      drops_next   = drops + DROP_W'(1);
    end else if (under) begin
      quality_next = (quality >= Q_MAX) ? Q_MAX : quality + QUAL_W'(1);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fps  <= FPS_RESET;
      freq <= FREQ_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_TARGET_FPS: fps  <= cfg_data[FPS_W-1:0];
        REG_TICK_FREQ:  freq <= cfg_data[DVS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Governor state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_gpu <= '0;
      avg_cpu <= '0;
      seeded  <= 1'b0;
      quality <= Q_MAX;
      drops   <= '0;
      use_smp <= 1'b0;
    end else begin
      if (ctl.ld_ms) use_smp <= s_tuser[0] && !s_tuser[1] && (freq != '0);
      if (ctl.pick && use_smp && !seeded) begin
        avg_gpu <= gpu_ms;
        avg_cpu <= cpu_ms;
        seeded  <= 1'b1;
      end
      if (ctl.avg_wr) begin
        avg_gpu <= quo0;
        avg_cpu <= quo1;
      end
      if (ctl.fin) begin
        quality <= quality_next;
        drops   <= drops_next;
      end
    end
  end

  // Per-frame payload registers.
  always_ff @(posedge clk) begin
    if (ctl.pick) present <= cpu_ms;
    if (ctl.ld_bud) prod <= prod_c;
    if (ctl.fin) begin
      o_gpu     <= avg_gpu;
      o_cpu     <= avg_cpu;
      o_present <= present;
      o_budget  <= budget;
      o_quality <= quality_next;
      o_drops   <= drops_next;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ctl.fin) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {6'b0, o_drops, o_quality, o_budget, o_present, o_cpu, o_gpu};

  `ASSERT_PROP(a_qual_range, clk, rst, (quality >= Q_MIN) && (quality <= Q_MAX), "quality out of range")
  `ASSERT_PROP(a_seed_sticky, clk, rst, seeded |=> seeded, "seed flag fell")
  `ASSERT_PROP(a_fin_valid, clk, rst, ctl.fin |=> m_tvalid, "committed result not presented")

endmodule
